// ===== rtl/vcl_pkg.sv =====
// ----------------------------------------------------------------------------
// vcl_pkg
// Types and constants shared by the velocity command limiter.
// ----------------------------------------------------------------------------
package vcl_pkg;

  localparam logic [16:0] SCALE_ONE = 17'h10000;
  localparam logic [14:0] CAP_MAX   = 15'h7fff;

  localparam int DIV_N  = 32;  // dividend width of every divider
  localparam int DIV_M  = 16;  // divisor width of every divider
  localparam int SQ_K   = 17;  // root width of the brake term
  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_MARGIN   = 3'd0,
    REG_DECEL    = 3'd1,
    REG_REACTION = 3'd2,
    REG_STOP     = 3'd3,
    REG_SLOW     = 3'd4,
    REG_FLOOR    = 3'd5,
    REG_MIN_LIN  = 3'd6
  } reg_idx_e;

  localparam logic [15:0] RST_MARGIN   = 16'd0;
  localparam logic [15:0] RST_DECEL    = 16'd1024;
  localparam logic [15:0] RST_REACTION = 16'd512;
  localparam logic [15:0] RST_STOP     = 16'd256;
  localparam logic [15:0] RST_SLOW     = 16'd1024;
  localparam logic [16:0] RST_FLOOR    = 17'd16384;
  localparam logic [14:0] RST_MIN_LIN  = 15'd10;

  typedef struct packed {
    logic [15:0] margin;
    logic [15:0] decel;
    logic [15:0] reaction;
    logic [15:0] stop_clr;
    logic [15:0] slow_clr;
    logic [16:0] floor_v;
    logic [14:0] min_lin;
  } cfg_t;

  // sideband that rides along the ramp divider
  typedef struct packed {
    logic [15:0] v;
    logic [15:0] w;
    logic        hit;
    logic        tiny;
    logic [16:0] fl;
    logic        ge_slow;
    logic        le_stop;
  } ramp_tag_t;

  // sideband that rides along the angular divider
  typedef struct packed {
    logic [15:0] vo;
    logic [14:0] cap;
    logic [16:0] scale;
    logic        tiny;
    logic        hit;
    logic        neg;
    logic [15:0] wt;
  } ang_tag_t;

endpackage

// ===== rtl/velocity_command_limiter.sv =====
// ----------------------------------------------------------------------------
// velocity_command_limiter
// Braking-distance velocity limiter with APB register port.
// ----------------------------------------------------------------------------
// One command is taken every cycle (busy stays low). Its result word is on
// the ports after the stage A register, the ramp divider, stages C to F, the
// angular divider and the output register, marked by a one-cycle done strobe;
// the receiver cannot stall. The path holds two 32-stage radix-2 dividers in
// series: the proximity ramp divider (run beside the reaction divider and the
// 17-stage root) and the angular ratio divider.
module velocity_command_limiter (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [vcl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [15:0]       linear_vel_i,
  input  logic signed [15:0]       angular_vel_i,
  input  logic                     collision_predicted_i,
  input  logic [15:0]              collision_dist_i,
  input  logic [15:0]              clearance_i,
  output logic                     done_o,
  output logic signed [15:0]       linear_out_o,
  output logic signed [15:0]       angular_out_o,
  output logic [14:0]              speed_cap_o,
  output logic [16:0]              scale_used_o
);

  localparam int N      = vcl_pkg::DIV_N;
  localparam int M      = vcl_pkg::DIV_M;
  localparam int K      = vcl_pkg::SQ_K;
  localparam int SQ_DLY = N - K;

  // ---------------- registers ----------------
  vcl_pkg::cfg_t cfg_q;
  logic [2:0]    widx;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign widx   = paddr[vcl_pkg::ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.margin   <= vcl_pkg::RST_MARGIN;
      cfg_q.decel    <= vcl_pkg::RST_DECEL;
      cfg_q.reaction <= vcl_pkg::RST_REACTION;
      cfg_q.stop_clr <= vcl_pkg::RST_STOP;
      cfg_q.slow_clr <= vcl_pkg::RST_SLOW;
      cfg_q.floor_v  <= vcl_pkg::RST_FLOOR;
      cfg_q.min_lin  <= vcl_pkg::RST_MIN_LIN;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        vcl_pkg::REG_MARGIN:   cfg_q.margin   <= pwdata[15:0];
        vcl_pkg::REG_DECEL:    cfg_q.decel    <= pwdata[15:0];
        vcl_pkg::REG_REACTION: cfg_q.reaction <= pwdata[15:0];
        vcl_pkg::REG_STOP:     cfg_q.stop_clr <= pwdata[15:0];
        vcl_pkg::REG_SLOW:     cfg_q.slow_clr <= pwdata[15:0];
        vcl_pkg::REG_FLOOR:    cfg_q.floor_v  <= pwdata[16:0];
        vcl_pkg::REG_MIN_LIN:  cfg_q.min_lin  <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      vcl_pkg::REG_MARGIN:   prdata = {16'd0, cfg_q.margin};
      vcl_pkg::REG_DECEL:    prdata = {16'd0, cfg_q.decel};
      vcl_pkg::REG_REACTION: prdata = {16'd0, cfg_q.reaction};
      vcl_pkg::REG_STOP:     prdata = {16'd0, cfg_q.stop_clr};
      vcl_pkg::REG_SLOW:     prdata = {16'd0, cfg_q.slow_clr};
      vcl_pkg::REG_FLOOR:    prdata = {15'd0, cfg_q.floor_v};
      vcl_pkg::REG_MIN_LIN:  prdata = {17'd0, cfg_q.min_lin};
      default:               prdata = 32'd0;
    endcase
  end

  // ---------------- stage A: setup products ----------------
  logic [15:0] d_c;
  logic [16:0] fl_c;
  logic [15:0] span_c;
  logic [16:0] mag_c;

  assign d_c  = (collision_dist_i > cfg_q.margin) ? collision_dist_i - cfg_q.margin : 16'd0;
  assign fl_c = (cfg_q.floor_v > vcl_pkg::SCALE_ONE) ? vcl_pkg::SCALE_ONE :
                (cfg_q.floor_v == 17'd0) ? 17'd1 : cfg_q.floor_v;
  assign span_c = 16'(vcl_pkg::SCALE_ONE - fl_c);
  assign mag_c  = linear_vel_i[15] ? 17'(-{linear_vel_i[15], linear_vel_i})
                                   : {1'b0, linear_vel_i};

  logic               a_vld_q;
  vcl_pkg::ramp_tag_t a_tag_q;
  logic [N-1:0]       a_rnum_q;
  logic [M-1:0]       a_rden_q;
  logic [N-1:0]       a_xnum_q;
  logic [M-1:0]       a_xden_q;
  logic [2*K-1:0]     a_rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    a_tag_q.v       <= linear_vel_i;
    a_tag_q.w       <= angular_vel_i;
    a_tag_q.hit     <= collision_predicted_i;
    a_tag_q.tiny    <= mag_c <= {2'b00, cfg_q.min_lin};
    a_tag_q.fl      <= fl_c;
    a_tag_q.ge_slow <= clearance_i >= cfg_q.slow_clr;
    a_tag_q.le_stop <= clearance_i <= cfg_q.stop_clr;
    a_rnum_q        <= span_c * 16'(clearance_i - cfg_q.stop_clr);
    a_rden_q        <= 16'(cfg_q.slow_clr - cfg_q.stop_clr);
    a_xnum_q        <= {6'd0, d_c, 10'd0};
    a_xden_q        <= cfg_q.reaction;
    a_rad_q         <= {1'b0, 32'(cfg_q.decel * d_c), 1'b0};
  end

  // ---------------- stage B: dividers and root ----------------
  logic               b_vld;
  logic               x_vld;
  logic [N-1:0]       b_rq;
  logic [N-1:0]       b_xq;
  vcl_pkg::ramp_tag_t b_tag;
  logic               b_rz;
  logic [K-1:0]       sq_root;
  logic [K-1:0]       sq_dly_q [SQ_DLY];

  vcl_div #(.N(N), .M(M), .TW($bits(vcl_pkg::ramp_tag_t))) u_ramp_div (
    .clk_i, .rst_ni,
    .in_vld_i (a_vld_q),
    .num_i    (a_rnum_q),
    .den_i    (a_rden_q),
    .tag_i    (a_tag_q),
    .out_vld_o(b_vld),
    .quo_o    (b_rq),
    .tag_o    (b_tag)
  );

  vcl_div #(.N(N), .M(M), .TW(1)) u_react_div (
    .clk_i, .rst_ni,
    .in_vld_i (a_vld_q),
    .num_i    (a_xnum_q),
    .den_i    (a_xden_q),
    .tag_i    (a_xden_q == 16'd0),
    .out_vld_o(x_vld),
    .quo_o    (b_xq),
    .tag_o    (b_rz)
  );

  vcl_sqrt #(.K(K)) u_brake_sqrt (
    .clk_i,
    .rad_i (a_rad_q),
    .root_o(sq_root)
  );

  for (genvar i = 0; i < SQ_DLY; i++) begin : g_sqd
    always_ff @(posedge clk_i) begin
      sq_dly_q[i] <= (i == 0) ? sq_root : sq_dly_q[(i == 0) ? 0 : i-1];
    end
  end

  // ---------------- stage C: scale and cap ----------------
  logic [N-1:0]       lim_c;
  logic               c_vld_q;
  vcl_pkg::ramp_tag_t c_tag_q;
  logic [16:0]        c_scale_q;
  logic [14:0]        c_cap_q;

  always_comb begin
    lim_c = {{(N-K){1'b0}}, sq_dly_q[SQ_DLY-1]};
    if (!b_rz && b_xq < lim_c) begin
      lim_c = b_xq;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else begin
      c_vld_q <= b_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    c_tag_q   <= b_tag;
    c_scale_q <= b_tag.ge_slow ? vcl_pkg::SCALE_ONE :
                 b_tag.le_stop ? b_tag.fl : 17'(b_tag.fl + b_rq[16:0]);
    c_cap_q   <= (lim_c > {{(N-15){1'b0}}, vcl_pkg::CAP_MAX}) ? vcl_pkg::CAP_MAX
                                                              : lim_c[14:0];
  end

  // ---------------- stage D: scale products ----------------
  logic               d_vld_q;
  vcl_pkg::ramp_tag_t d_tag_q;
  logic [16:0]        d_scale_q;
  logic [14:0]        d_cap_q;
  logic signed [33:0] d_pv_q;
  logic signed [33:0] d_pw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d_tag_q   <= c_tag_q;
    d_scale_q <= c_scale_q;
    d_cap_q   <= c_cap_q;
    d_pv_q    <= $signed(c_tag_q.v) * $signed({1'b0, c_scale_q});
    d_pw_q    <= $signed(c_tag_q.w) * $signed({1'b0, c_scale_q});
  end

  // ---------------- stage E: truncate and clamp ----------------
  logic signed [33:0] pv_adj;
  logic signed [33:0] pw_adj;
  logic signed [17:0] vs_c;
  logic signed [17:0] capp_c;
  logic signed [17:0] vo_c;
  logic               e_vld_q;
  vcl_pkg::ramp_tag_t e_tag_q;
  logic [16:0]        e_scale_q;
  logic [14:0]        e_cap_q;
  logic [15:0]        e_vo_q;
  logic [15:0]        e_wt_q;

  assign pv_adj = d_pv_q[33] ? d_pv_q + 34'sd65535 : d_pv_q;
  assign pw_adj = d_pw_q[33] ? d_pw_q + 34'sd65535 : d_pw_q;
  assign vs_c   = 18'(pv_adj >>> 16);
  assign capp_c = $signed({3'b000, d_cap_q});

  always_comb begin
    vo_c = vs_c;
    if (vs_c > capp_c) begin
      vo_c = capp_c;
    end else if (vs_c < -capp_c) begin
      vo_c = -capp_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    e_tag_q   <= d_tag_q;
    e_scale_q <= d_scale_q;
    e_cap_q   <= d_cap_q;
    e_vo_q    <= vo_c[15:0];
    e_wt_q    <= pw_adj[31:16];
  end

  // ---------------- stage F: angular numerator ----------------
  logic [15:0]       aw_c;
  logic [15:0]       avo_c;
  logic              f_vld_q;
  vcl_pkg::ang_tag_t f_tag_q;
  logic [N-1:0]      f_num_q;
  logic [M-1:0]      f_den_q;

  assign aw_c  = e_tag_q.w[15] ? 16'(-e_tag_q.w) : e_tag_q.w;
  assign avo_c = e_vo_q[15] ? 16'(-e_vo_q) : e_vo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= e_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f_tag_q.vo    <= e_vo_q;
    f_tag_q.cap   <= e_cap_q;
    f_tag_q.scale <= e_scale_q;
    f_tag_q.tiny  <= e_tag_q.tiny;
    f_tag_q.hit   <= e_tag_q.hit;
    f_tag_q.neg   <= e_tag_q.w[15] ^ e_vo_q[15] ^ e_tag_q.v[15];
    f_tag_q.wt    <= e_wt_q;
    f_num_q       <= aw_c * avo_c;
    f_den_q       <= e_tag_q.v[15] ? 16'(-e_tag_q.v) : e_tag_q.v;
  end

  // ---------------- stage G: angular ratio ----------------
  logic              g_vld;
  logic [N-1:0]      g_q;
  vcl_pkg::ang_tag_t g_tag;

  vcl_div #(.N(N), .M(M), .TW($bits(vcl_pkg::ang_tag_t))) u_ang_div (
    .clk_i, .rst_ni,
    .in_vld_i (f_vld_q),
    .num_i    (f_num_q),
    .den_i    (f_den_q),
    .tag_i    (f_tag_q),
    .out_vld_o(g_vld),
    .quo_o    (g_q),
    .tag_o    (g_tag)
  );

  // ---------------- output word ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= g_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    linear_out_o  <= g_tag.vo;
    speed_cap_o   <= g_tag.cap;
    scale_used_o  <= g_tag.scale;
    if (g_tag.tiny) begin
      angular_out_o <= g_tag.hit ? 16'sd0 : g_tag.wt;
    end else begin
      angular_out_o <= g_tag.neg ? 16'(-g_q[15:0]) : g_q[15:0];
    end
  end

  // ---------------- checks ----------------
  a_div_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vld == x_vld) else $error("ramp and reaction dividers out of step");

  a_cap_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && speed_cap_o == 15'd0 |-> linear_out_o == 16'sd0)
    else $error("nonzero speed with zero cap");

  a_scale_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> scale_used_o != 17'd0 && scale_used_o <= vcl_pkg::SCALE_ONE)
    else $error("scale out of range");

  a_lin_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> linear_out_o <= $signed({1'b0, speed_cap_o}) &&
               linear_out_o >= -$signed({1'b0, speed_cap_o}))
    else $error("speed exceeds cap");

endmodule

// ===== rtl/vcl_div.sv =====
// ----------------------------------------------------------------------------
// vcl_div
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
module vcl_div #(
  parameter int N  = 32,
  parameter int M  = 16,
  parameter int TW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_vld_i,
  input  logic [N-1:0]  num_i,
  input  logic [M-1:0]  den_i,
  input  logic [TW-1:0] tag_i,
  output logic          out_vld_o,
  output logic [N-1:0]  quo_o,
  output logic [TW-1:0] tag_o
);

  logic [M-1:0]  rem_q [N];
  logic [N-1:0]  num_q [N];
  logic [N-1:0]  quo_q [N];
  logic [M-1:0]  den_q [N];
  logic [TW-1:0] tag_q [N];
  logic          vld_q [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [M-1:0]  r_in;
    logic [N-1:0]  n_in;
    logic [N-1:0]  q_in;
    logic [M-1:0]  d_in;
    logic [TW-1:0] t_in;
    logic          v_in;
    logic [M:0]    trial;
    logic [M:0]    diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign r_in = '0;
      assign n_in = num_i;
      assign q_in = '0;
      assign d_in = den_i;
      assign t_in = tag_i;
      assign v_in = in_vld_i;
    end else begin : g_next
      assign r_in = rem_q[s-1];
      assign n_in = num_q[s-1];
      assign q_in = quo_q[s-1];
      assign d_in = den_q[s-1];
      assign t_in = tag_q[s-1];
      assign v_in = vld_q[s-1];
    end

    assign trial = {r_in, n_in[N-1]};
    assign ge    = trial >= {1'b0, d_in};
    assign diff  = trial - {1'b0, d_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? diff[M-1:0] : trial[M-1:0];
      num_q[s] <= {n_in[N-2:0], 1'b0};
      quo_q[s] <= {q_in[N-2:0], ge};
      den_q[s] <= d_in;
      tag_q[s] <= t_in;
    end
  end

  assign out_vld_o = vld_q[N-1];
  assign quo_o     = quo_q[N-1];
  assign tag_o     = tag_q[N-1];

endmodule

// ===== rtl/vcl_sqrt.sv =====
// ----------------------------------------------------------------------------
// vcl_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module vcl_sqrt #(
  parameter int K = 17
) (
  input  logic           clk_i,
  input  logic [2*K-1:0] rad_i,
  output logic [K-1:0]   root_o
);

  logic [K+1:0]   rem_q [K];
  logic [K-1:0]   rt_q  [K];
  logic [2*K-1:0] x_q   [K];

  for (genvar s = 0; s < K; s++) begin : g_stage
    logic [K+1:0]   r_in;
    logic [K-1:0]   rt_in;
    logic [2*K-1:0] x_in;
    logic [K+3:0]   t;
    logic [K+3:0]   trial;
    logic [K+3:0]   diff;
    logic           ge;

    if (s == 0) begin : g_first
      assign r_in  = '0;
      assign rt_in = '0;
      assign x_in  = rad_i;
    end else begin : g_next
      assign r_in  = rem_q[s-1];
      assign rt_in = rt_q[s-1];
      assign x_in  = x_q[s-1];
    end

    assign t     = {r_in, x_in[2*K-1 -: 2]};
    assign trial = {2'b00, rt_in, 2'b01};
    assign ge    = t >= trial;
    assign diff  = t - trial;

    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? diff[K+1:0] : t[K+1:0];
      rt_q[s]  <= {rt_in[K-2:0], ge};
      x_q[s]   <= {x_in[2*K-3:0], 2'b00};
    end
  end

  assign root_o = rt_q[K-1];

endmodule

// ===== sim/vcl_checker.sv =====
// ----------------------------------------------------------------------------
// vcl_checker
// Watches the APB port, the command port and the result port of the
// velocity command limiter, predicts each result word and compares it.
// ----------------------------------------------------------------------------
module vcl_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [vcl_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] linear_vel_i,
  input  logic signed [15:0] angular_vel_i,
  input  logic               collision_predicted_i,
  input  logic [15:0]        collision_dist_i,
  input  logic [15:0]        clearance_i,
  input  logic               done_o,
  input  logic signed [15:0] linear_out_o,
  input  logic signed [15:0] angular_out_o,
  input  logic [14:0]        speed_cap_o,
  input  logic [16:0]        scale_used_o,
  output int                 err_cnt_o,
  output int                 pending_o,
  output int                 result_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] lin;
    logic signed [15:0] ang;
    logic [14:0]        cap;
    logic [16:0]        scale;
  } limit_word_t;

  vcl_pkg::cfg_t cfg;
  limit_word_t   limit_q[$];

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic limit_word_t predict_word(longint v, longint w, bit hit,
                                               longint unsigned c_dist,
                                               longint unsigned clr);
    limit_word_t     res;
    longint unsigned fl, sc, d, cap, rt;
    longint          vo, wo, mag;
    bit              tiny;
    fl = cfg.floor_v;
    if (fl > 65536) fl = 65536;
    if (fl == 0) fl = 1;
    if (clr >= cfg.slow_clr) sc = 65536;
    else if (clr <= cfg.stop_clr) sc = fl;
    else sc = fl + (65536 - fl) * (clr - cfg.stop_clr) / (cfg.slow_clr - cfg.stop_clr);
    d = (c_dist > cfg.margin) ? c_dist - cfg.margin : 0;
    cap = int_sqrt(2 * longint'(cfg.decel) * d);
    if (cfg.reaction != 0) begin
      rt = d * 1024 / cfg.reaction;
      if (rt < cap) cap = rt;
    end
    if (cap > 32767) cap = 32767;
    vo = v * longint'(sc) / 65536;
    mag = (v < 0) ? -v : v;
    tiny = mag <= longint'(cfg.min_lin);
    if (vo > longint'(cap)) vo = cap;
    if (vo < -longint'(cap)) vo = -longint'(cap);
    if (!tiny) wo = w * vo / v;
    else wo = w * longint'(sc) / 65536;
    if (hit && tiny) wo = 0;
    res.lin = vo[15:0];
    res.ang = wo[15:0];
    res.cap = cap[14:0];
    res.scale = sc[16:0];
    return res;
  endfunction

  assign pending_o = limit_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    limit_word_t e;
    if (!rst_ni) begin
      cfg <= '{vcl_pkg::RST_MARGIN, vcl_pkg::RST_DECEL, vcl_pkg::RST_REACTION,
               vcl_pkg::RST_STOP, vcl_pkg::RST_SLOW, vcl_pkg::RST_FLOOR,
               vcl_pkg::RST_MIN_LIN};
      err_cnt_o <= 0;
      result_cnt_o <= 0;
      limit_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (vcl_pkg::reg_idx_e'(paddr >> 2))
          vcl_pkg::REG_MARGIN:   cfg.margin   <= pwdata[15:0];
          vcl_pkg::REG_DECEL:    cfg.decel    <= pwdata[15:0];
          vcl_pkg::REG_REACTION: cfg.reaction <= pwdata[15:0];
          vcl_pkg::REG_STOP:     cfg.stop_clr <= pwdata[15:0];
          vcl_pkg::REG_SLOW:     cfg.slow_clr <= pwdata[15:0];
          vcl_pkg::REG_FLOOR:    cfg.floor_v  <= pwdata[16:0];
          vcl_pkg::REG_MIN_LIN:  cfg.min_lin  <= pwdata[14:0];
          default: ;
        endcase
      end
      if (start && !busy)
        limit_q.push_back(predict_word(linear_vel_i, angular_vel_i, collision_predicted_i,
                                       collision_dist_i, clearance_i));
      if (done_o) begin
        result_cnt_o <= result_cnt_o + 1;
        if (limit_q.size() == 0) begin
          $display("%0t: unexpected result word", $time);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          e = limit_q.pop_front();
          if (e !== {linear_out_o, angular_out_o, speed_cap_o, scale_used_o}) begin
            $display("%0t: mismatch exp lin=%0d ang=%0d cap=%0d scale=%0d", $time,
                     e.lin, e.ang, e.cap, e.scale);
            $display("%0t:          act lin=%0d ang=%0d cap=%0d scale=%0d", $time,
                     linear_out_o, angular_out_o, speed_cap_o, scale_used_o);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end
    end
  end
endmodule

// ===== sim/velocity_command_limiter_tb.sv =====
// ----------------------------------------------------------------------------
// velocity_command_limiter_tb
// Drives directed and random velocity commands through several register
// settings, with random gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module velocity_command_limiter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AW         = vcl_pkg::ADDR_W;
  localparam int LATENCY    = 70;
  localparam int MAX_CYCLES = 200000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AW-1:0]      paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               start = 1'b0;
  logic               busy;
  logic signed [15:0] linear_vel_i = '0, angular_vel_i = '0;
  logic               collision_predicted_i = 1'b0;
  logic [15:0]        collision_dist_i = '0, clearance_i = '0;
  logic               done_o;
  logic signed [15:0] linear_out_o, angular_out_o;
  logic [14:0]        speed_cap_o;
  logic [16:0]        scale_used_o;
  int                 err_cnt, pending, result_cnt;
  int                 cycle_cnt = 0;
  bit                 calm = 0;

  always #5 clk_i = ~clk_i;

  velocity_command_limiter u_top (.*);

  vcl_checker u_chk (.*, .err_cnt_o(err_cnt), .pending_o(pending),
                     .result_cnt_o(result_cnt));

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic reg_write(vcl_pkg::reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1; penable = 0; pwrite = 1; paddr = AW'(idx) << 2; pwdata = val;
    @(negedge clk_i);
    penable = 1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 0; penable = 0; pwrite = 0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (LATENCY + 5) @(negedge clk_i);
  endtask

  task automatic send_cmd(logic [15:0] v, logic [15:0] w, logic hit, logic [15:0] c_dist,
                          logic [15:0] clr);
    if (!calm && $urandom_range(0, 4) == 0) begin
      start = 0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    start = 1;
    linear_vel_i = v; angular_vel_i = w; collision_predicted_i = hit;
    collision_dist_i = c_dist; clearance_i = clr;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic random_cmds(int n);
    logic [15:0] v;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: v = 16'($signed($urandom_range(0, 40)) - 20);
        1: v = 16'($urandom);
        default: v = 16'($signed($urandom_range(0, 4000)) - 2000);
      endcase
      send_cmd(v, 16'($urandom), 1'($urandom),
               16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4000)),
               16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1500)));
    end
    start = 0;
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);
    // directed: extremes and corner cases at reset settings
    send_cmd(16'h7fff, 16'h7fff, 0, 16'hffff, 16'hffff);
    send_cmd(16'h8000, 16'h8000, 1, 16'hffff, 16'h0000);
    send_cmd(16'd5, 16'h7fff, 1, 16'd100, 16'd500);
    send_cmd(16'd5, 16'h8000, 0, 16'd100, 16'd500);
    send_cmd(16'hfff6, 16'd1000, 1, 16'd0, 16'd256);
    send_cmd(16'd11, 16'hffff, 1, 16'd2000, 16'd1024);
    send_cmd(16'd3000, 16'd700, 0, 16'd0, 16'd1023);
    send_cmd(16'hc000, 16'h4000, 1, 16'd50, 16'd257);
    start = 0;
    drain();
    reg_write(vcl_pkg::REG_MARGIN, 32'hffff);
    reg_write(vcl_pkg::REG_DECEL, 32'd0);
    reg_write(vcl_pkg::REG_REACTION, 32'd0);
    reg_write(vcl_pkg::REG_STOP, 32'd1000);
    reg_write(vcl_pkg::REG_SLOW, 32'd500);
    reg_write(vcl_pkg::REG_FLOOR, 32'h1ffff);
    reg_write(vcl_pkg::REG_MIN_LIN, 32'h7fff);
    send_cmd(16'h7fff, 16'd77, 1, 16'hffff, 16'd499);
    send_cmd(16'h8000, 16'd77, 0, 16'hffff, 16'd500);
    send_cmd(16'd100, 16'd77, 1, 16'd10, 16'd2000);
    start = 0;
    drain();
    reg_write(vcl_pkg::REG_MARGIN, 32'd0);
    reg_write(vcl_pkg::REG_DECEL, 32'hffff);
    reg_write(vcl_pkg::REG_REACTION, 32'd1);
    reg_write(vcl_pkg::REG_FLOOR, 32'd0);
    reg_write(vcl_pkg::REG_MIN_LIN, 32'd0);
    reg_write(vcl_pkg::REG_STOP, 32'd0);
    reg_write(vcl_pkg::REG_SLOW, 32'hffff);
    send_cmd(16'd0, 16'h7fff, 1, 16'hffff, 16'h8000);
    send_cmd(16'd1, 16'h8000, 0, 16'h1, 16'hfffe);
    send_cmd(16'h7fff, 16'h8000, 1, 16'hffff, 16'h0);
    random_cmds(300);
    drain();
    // random settings phases
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(vcl_pkg::REG_MARGIN, $urandom_range(0, 1000));
      reg_write(vcl_pkg::REG_DECEL, $urandom_range(0, 5000));
      reg_write(vcl_pkg::REG_REACTION, $urandom_range(0, 2000));
      reg_write(vcl_pkg::REG_STOP, $urandom_range(0, 600));
      reg_write(vcl_pkg::REG_SLOW, $urandom_range(0, 1500));
      reg_write(vcl_pkg::REG_FLOOR, $urandom_range(0, 70000));
      reg_write(vcl_pkg::REG_MIN_LIN, $urandom_range(0, 50));
      if (ph == 3) calm = 1;
      random_cmds(280);
      drain();
    end
    $display("Ran %0d result words over seven register settings,", result_cnt);
    $display("covering ramp edges, cap limits and near-zero commands.");
    if (err_cnt == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
